// ----- hw/rtl/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and constants shared by the sphere/box collision pipeline.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int COORD_W   = 32;               // Q16.16 coordinate
   localparam int RADIUS_W  = 31;               // unsigned Q15.16 radius
   localparam int OFF_W     = COORD_W + 1;      // exact signed offset
   localparam int SQ_W      = 2 * COORD_W + 1;  // square of an offset magnitude
   localparam int SUM_W     = SQ_W + 1;         // sum of three squares
   localparam int ROOT_W    = 34;               // floor square root of the sum
   localparam int QUO_W     = 32;               // push quotient magnitude
   localparam int PROD_W    = 2 * QUO_W;        // offset times distance magnitude
   localparam int SQRT_STEP = 2;                // root bits per pipeline stage
   localparam int DIV_STEP  = 2;                // quotient bits per pipeline stage

   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   typedef struct packed {
      logic signed [COORD_W-1:0]  sphere_x;
      logic signed [COORD_W-1:0]  sphere_y;
      logic signed [COORD_W-1:0]  sphere_z;
      logic        [RADIUS_W-1:0] sphere_radius;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_min_z;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
      logic signed [COORD_W-1:0]  box_max_z;
   } req_payload_type;

   typedef struct packed {
      logic                      collided;
      logic signed [COORD_W-1:0] signed_distance;
      logic signed [COORD_W-1:0] push_x;
      logic signed [COORD_W-1:0] push_y;
      logic signed [COORD_W-1:0] push_z;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/sphere_box_collision_unit.sv -----
// ----------------------------------------------------------------------------
// sphere_box_collision_unit
// Sphere versus axis-aligned box test: closest point, signed distance,
// collided flag and push vector, all in Q16.16.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------
//   req_     | in        | req_valid/req_ready  | req_payload_type
//   rsp_     | out       | rsp_valid/rsp_ready  | rsp_payload_type
//
// Takes one item per cycle. From acceptance to rsp_valid an item passes through
// clamp, square, sum (3), square root at two bits a stage (17), distance and
// product (2), three lane divider at two bits a stage (16), output buffer (1).
// The whole pipeline advances on one enable, held low only while the
// two-entry output buffer is full; a stall freezes every stage in place.
// Reset clears the valid bits and the buffer count only.
//
module sphere_box_collision_unit import sbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int SideW = 3 * OFF_W + RADIUS_W;
   localparam int Lane0SideW = 3 + COORD_W;

   logic en;

   // ---- stage 1: clamp the centre to the box, take the offset -------------
   logic                     v1_ff;
   logic signed [OFF_W-1:0]  off1_ff [3];
   logic signed [OFF_W-1:0]  off1_in [3];
   logic [RADIUS_W-1:0]      rad1_ff;

   always_comb begin
      logic signed [COORD_W-1:0] c [3];
      logic signed [COORD_W-1:0] lo [3];
      logic signed [COORD_W-1:0] hi [3];
      logic signed [COORD_W-1:0] p;
      c[0]  = req_payload.sphere_x;
      c[1]  = req_payload.sphere_y;
      c[2]  = req_payload.sphere_z;
      lo[0] = req_payload.box_min_x;
      lo[1] = req_payload.box_min_y;
      lo[2] = req_payload.box_min_z;
      hi[0] = req_payload.box_max_x;
      hi[1] = req_payload.box_max_y;
      hi[2] = req_payload.box_max_z;
      for (int i = 0; i < 3; i++) begin
         // min against the max corner first, then max against the min corner
         p = (c[i] < hi[i]) ? c[i] : hi[i];
         if (lo[i] > p) begin
            p = lo[i];
         end
         off1_in[i] = OFF_W'(p) - OFF_W'(c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off1_ff <= off1_in;
         rad1_ff <= req_payload.sphere_radius;
      end
   end

   // ---- stage 2: square each offset magnitude ----------------------------
   // a magnitude with the top bit set is exactly 2^32, so its square is 2^64
   logic                     v2_ff;
   logic signed [OFF_W-1:0]  off2_ff [3];
   logic [SQ_W-1:0]          sq2_ff  [3];
   logic [SQ_W-1:0]          sq2_in  [3];
   logic [RADIUS_W-1:0]      rad2_ff;

   always_comb begin
      logic [OFF_W-1:0]     m;
      logic [2*COORD_W-1:0] pr;
      for (int i = 0; i < 3; i++) begin
         m  = off1_ff[i][OFF_W-1] ? OFF_W'(-off1_ff[i]) : OFF_W'(off1_ff[i]);
         pr = {{COORD_W{1'b0}}, m[COORD_W-1:0]} * {{COORD_W{1'b0}}, m[COORD_W-1:0]};
         sq2_in[i] = m[OFF_W-1] ? {1'b1, {(SQ_W-1){1'b0}}} : {1'b0, pr};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off2_ff <= off1_ff;
         sq2_ff  <= sq2_in;
         rad2_ff <= rad1_ff;
      end
   end

   // ---- stage 3: sum of squares -----------------------------------------
   logic                     v3_ff;
   logic signed [OFF_W-1:0]  off3_ff [3];
   logic [SUM_W-1:0]         sum3_ff;
   logic [RADIUS_W-1:0]      rad3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off3_ff <= off2_ff;
         sum3_ff <= SUM_W'(sq2_ff[0]) + SUM_W'(sq2_ff[1]) + SUM_W'(sq2_ff[2]);
         rad3_ff <= rad2_ff;
      end
   end

   // ---- square root ------------------------------------------------------
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   logic [SideW-1:0]  sq_side;

   sbc_sqrt #(
      .RootW (ROOT_W),
      .Step  (SQRT_STEP),
      .SideW (SideW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v3_ff),
      .in_rad   ((2*ROOT_W)'(sum3_ff)),
      .in_side  ({off3_ff[0], off3_ff[1], off3_ff[2], rad3_ff}),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // ---- stage 4: distance, saturate, magnitudes --------------------------
   logic                     v4_ff;
   logic                     coll4_ff, coll4_in;
   logic [COORD_W-1:0]       sd4_ff,   sd4_in;
   logic [COORD_W-1:0]       sdm4_ff,  sdm4_in;
   logic [ROOT_W-1:0]        root4_ff;
   logic [OFF_W-1:0]         mag4_ff  [3];
   logic [OFF_W-1:0]         mag4_in  [3];
   logic                     neg4_ff  [3];
   logic                     neg4_in  [3];

   always_comb begin
      logic [ROOT_W+1:0]       d;
      logic signed [OFF_W-1:0] o [3];
      logic [RADIUS_W-1:0]     r;
      {o[0], o[1], o[2], r} = sq_side;
      d        = {2'b00, sq_root} - (ROOT_W+2)'(r);
      coll4_in = d[ROOT_W+1];
      // only the positive side can overflow: radius fits in 31 bits
      if (!d[ROOT_W+1] && (|d[ROOT_W:COORD_W-1])) begin
         sd4_in = SAT_MAX;
      end else begin
         sd4_in = d[COORD_W-1:0];
      end
      sdm4_in = sd4_in[COORD_W-1] ? COORD_W'(-sd4_in) : sd4_in;
      for (int i = 0; i < 3; i++) begin
         neg4_in[i] = o[i][OFF_W-1];
         mag4_in[i] = o[i][OFF_W-1] ? OFF_W'(-o[i]) : OFF_W'(o[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coll4_ff <= coll4_in;
         sd4_ff   <= sd4_in;
         sdm4_ff  <= sdm4_in;
         root4_ff <= sq_root;
         mag4_ff  <= mag4_in;
         neg4_ff  <= neg4_in;
      end
   end

   // ---- stage 5: offset magnitude times distance magnitude ---------------
   logic                 v5_ff;
   logic                 coll5_ff;
   logic [COORD_W-1:0]   sd5_ff;
   logic [ROOT_W-1:0]    root5_ff;
   logic                 zero5_ff;
   logic [PROD_W-1:0]    prod5_ff [3];
   logic [PROD_W-1:0]    prod5_in [3];
   logic                 sign5_ff [3];
   logic                 sign5_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod5_in[i] = mag4_ff[i][OFF_W-1] ? {sdm4_ff, {QUO_W{1'b0}}}
                     : {{QUO_W{1'b0}}, mag4_ff[i][COORD_W-1:0]} *
                       {{QUO_W{1'b0}}, sdm4_ff};
         sign5_in[i] = neg4_ff[i] ^ sd4_ff[COORD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coll5_ff <= coll4_ff;
         sd5_ff   <= sd4_ff;
         root5_ff <= root4_ff;
         zero5_ff <= (root4_ff == '0);
         prod5_ff <= prod5_in;
         sign5_ff <= sign5_in;
      end
   end

   // ---- divide each product by the length --------------------------------
   logic                  dv_vld;
   logic [QUO_W-1:0]      quo [3];
   logic [Lane0SideW-1:0] side0;
   logic                  sign1, sign2;

   sbc_div #(
      .DivW  (ROOT_W),
      .QuoW  (QUO_W),
      .Step  (DIV_STEP),
      .SideW (Lane0SideW)
   ) u_div_x (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_vld      (v5_ff),
      .in_dividend (prod5_ff[0]),
      .in_divisor  (root5_ff),
      .in_side     ({sign5_ff[0], coll5_ff, zero5_ff, sd5_ff}),
      .out_vld     (dv_vld),
      .out_quo     (quo[0]),
      .out_side    (side0)
   );

   sbc_div #(
      .DivW  (ROOT_W),
      .QuoW  (QUO_W),
      .Step  (DIV_STEP),
      .SideW (1)
   ) u_div_y (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_vld      (v5_ff),
      .in_dividend (prod5_ff[1]),
      .in_divisor  (root5_ff),
      .in_side     (sign5_ff[1]),
      .out_vld     (),
      .out_quo     (quo[1]),
      .out_side    (sign1)
   );

   sbc_div #(
      .DivW  (ROOT_W),
      .QuoW  (QUO_W),
      .Step  (DIV_STEP),
      .SideW (1)
   ) u_div_z (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_vld      (v5_ff),
      .in_dividend (prod5_ff[2]),
      .in_divisor  (root5_ff),
      .in_side     (sign5_ff[2]),
      .out_vld     (),
      .out_quo     (quo[2]),
      .out_side    (sign2)
   );

   // ---- apply signs, build the result item --------------------------------
   rsp_payload_type res;

   always_comb begin
      logic               sgn [3];
      logic               zero;
      logic [COORD_W-1:0] pv  [3];
      sgn[0] = side0[Lane0SideW-1];
      sgn[1] = sign1;
      sgn[2] = sign2;
      zero   = side0[COORD_W];
      for (int i = 0; i < 3; i++) begin
         if (zero) begin
            pv[i] = '0;
         end else if (sgn[i]) begin
            pv[i] = COORD_W'(-quo[i]);
         end else if (quo[i][QUO_W-1]) begin
            pv[i] = SAT_MAX;
         end else begin
            pv[i] = quo[i];
         end
      end
      res.collided        = side0[Lane0SideW-2];
      res.signed_distance = side0[COORD_W-1:0];
      res.push_x          = pv[0];
      res.push_y          = pv[1];
      res.push_z          = pv[2];
   end

   // ---- two-entry output buffer ------------------------------------------
   // hold the pipeline only when both entries are taken
   logic [1:0]      cnt_ff, cnt_in;
   rsp_payload_type head_ff, head_in;
   rsp_payload_type tail_ff, tail_in;
   logic            push, pop;

   assign en   = (cnt_ff != 2'd2);
   assign push = en && dv_vld;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (pop && push) begin
         if (cnt_ff == 2'd1) begin
            head_in = res;
         end else begin
            head_in = tail_ff;
            tail_in = res;
         end
      end else if (pop) begin
         head_in = tail_ff;
         cnt_in  = cnt_ff - 2'd1;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_in = res;
         end else begin
            tail_in = res;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign req_ready   = en;
   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = head_ff;

endmodule

// ----- hw/rtl/sbc_sqrt.sv -----
// ----------------------------------------------------------------------------
// sbc_sqrt
// Pipelined floor square root, Step root bits per stage, with sideband.
// ----------------------------------------------------------------------------
module sbc_sqrt import sbc_pkg::*; #(
   parameter int RootW = ROOT_W,
   parameter int Step  = SQRT_STEP,
   parameter int SideW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [2*RootW-1:0] in_rad,
   input  logic [SideW-1:0]   in_side,
   output logic               out_vld,
   output logic [RootW-1:0]   out_root,
   output logic [SideW-1:0]   out_side
);

   localparam int Stages = RootW / Step;
   localparam int RadW   = 2 * RootW;
   localparam int RemW   = RootW + 4;

   logic               vld_s  [Stages+1];
   logic [RadW-1:0]    rad_s  [Stages+1];
   logic [RemW-1:0]    rem_s  [Stages+1];
   logic [RootW-1:0]   root_s [Stages+1];
   logic [SideW-1:0]   side_s [Stages+1];

   assign vld_s[0]  = in_vld;
   assign rad_s[0]  = in_rad;
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign side_s[0] = in_side;

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      logic             vld_ff;
      logic [RadW-1:0]  rad_ff,  rad_in;
      logic [RemW-1:0]  rem_ff,  rem_in;
      logic [RootW-1:0] root_ff, root_in;
      logic [SideW-1:0] side_ff;

      // restoring digit recurrence, two radicand bits per root bit
      always_comb begin
         logic [RemW-1:0]  r;
         logic [RemW-1:0]  trial;
         logic [RootW-1:0] q;
         logic [RadW-1:0]  d;
         r = rem_s[g];
         q = root_s[g];
         d = rad_s[g];
         for (int k = 0; k < Step; k++) begin
            r     = {r[RemW-3:0], d[RadW-1 -: 2]};
            d     = {d[RadW-3:0], 2'b00};
            trial = {{(RemW-RootW-2){1'b0}}, q, 2'b01};
            if (r >= trial) begin
               r = r - trial;
               q = {q[RootW-2:0], 1'b1};
            end else begin
               q = {q[RootW-2:0], 1'b0};
            end
         end
         rem_in  = r;
         root_in = q;
         rad_in  = d;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_s[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_s[g];
         end
      end

      assign vld_s[g+1]  = vld_ff;
      assign rad_s[g+1]  = rad_ff;
      assign rem_s[g+1]  = rem_ff;
      assign root_s[g+1] = root_ff;
      assign side_s[g+1] = side_ff;
   end

   assign out_vld  = vld_s[Stages];
   assign out_root = root_s[Stages];
   assign out_side = side_s[Stages];

endmodule

// ----- hw/rtl/sbc_div.sv -----
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined unsigned restoring divider, Step quotient bits per stage.
// Dividend must be below divisor * 2^QuoW.
// ----------------------------------------------------------------------------
module sbc_div import sbc_pkg::*; #(
   parameter int DivW  = ROOT_W,
   parameter int QuoW  = QUO_W,
   parameter int Step  = DIV_STEP,
   parameter int SideW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [2*QuoW-1:0] in_dividend,
   input  logic [DivW-1:0]   in_divisor,
   input  logic [SideW-1:0]  in_side,
   output logic              out_vld,
   output logic [QuoW-1:0]   out_quo,
   output logic [SideW-1:0]  out_side
);

   localparam int Stages = QuoW / Step;
   localparam int RemW   = DivW + 1;

   logic             vld_s  [Stages+1];
   logic [RemW-1:0]  rem_s  [Stages+1];
   logic [QuoW-1:0]  lo_s   [Stages+1];
   logic [QuoW-1:0]  quo_s  [Stages+1];
   logic [DivW-1:0]  dvs_s  [Stages+1];
   logic [SideW-1:0] side_s [Stages+1];

   assign vld_s[0]  = in_vld;
   assign rem_s[0]  = RemW'(in_dividend[2*QuoW-1:QuoW]);
   assign lo_s[0]   = in_dividend[QuoW-1:0];
   assign quo_s[0]  = '0;
   assign dvs_s[0]  = in_divisor;
   assign side_s[0] = in_side;

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      logic             vld_ff;
      logic [RemW-1:0]  rem_ff, rem_in;
      logic [QuoW-1:0]  lo_ff,  lo_in;
      logic [QuoW-1:0]  quo_ff, quo_in;
      logic [DivW-1:0]  dvs_ff;
      logic [SideW-1:0] side_ff;

      always_comb begin
         logic [RemW-1:0] r;
         logic [QuoW-1:0] l;
         logic [QuoW-1:0] q;
         r = rem_s[g];
         l = lo_s[g];
         q = quo_s[g];
         for (int k = 0; k < Step; k++) begin
            r = {r[RemW-2:0], l[QuoW-1]};
            l = {l[QuoW-2:0], 1'b0};
            if (r >= {1'b0, dvs_s[g]}) begin
               r = r - {1'b0, dvs_s[g]};
               q = {q[QuoW-2:0], 1'b1};
            end else begin
               q = {q[QuoW-2:0], 1'b0};
            end
         end
         rem_in = r;
         lo_in  = l;
         quo_in = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_s[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            lo_ff   <= lo_in;
            quo_ff  <= quo_in;
            dvs_ff  <= dvs_s[g];
            side_ff <= side_s[g];
         end
      end

      assign vld_s[g+1]  = vld_ff;
      assign rem_s[g+1]  = rem_ff;
      assign lo_s[g+1]   = lo_ff;
      assign quo_s[g+1]  = quo_ff;
      assign dvs_s[g+1]  = dvs_ff;
      assign side_s[g+1] = side_ff;
   end

   assign out_vld  = vld_s[Stages];
   assign out_quo  = quo_s[Stages];
   assign out_side = side_s[Stages];

endmodule

// ----- hw/rtl/sbc_checker.sv -----
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the collision unit, attached by bind.
// ----------------------------------------------------------------------------
module sbc_checker import sbc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // a held result item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // collided is exactly the sign of the distance
   a_coll_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.collided == rsp_payload.signed_distance[COORD_W-1])
      else $error("collided disagrees with signed distance");

   // zero distance scales the push vector to nothing
   a_zero_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.signed_distance == '0 |->
         rsp_payload.push_x == '0 && rsp_payload.push_y == '0 &&
         rsp_payload.push_z == '0)
      else $error("push not zero at zero distance");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind sphere_box_collision_unit sbc_checker u_sbc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- verif/sphere_box_collision_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_box_collision_unit_test
// Self-checking bench for the sphere/box collision pipeline: a directed table
// of corner pairs, then random pairs, each result matched to a typed-in value
// or a local fixed-point model of the clamp, root, distance and push vector.
// ----------------------------------------------------------------------------
module sphere_box_collision_unit_test;
   import sbc_pkg::*;

   localparam int LATENCY   = 39;
   localparam int N_RANDOM  = 1330;
   localparam int MAX_SHOWN = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   sphere_box_collision_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Queue of predicted results, oldest first.
   rsp_payload_type pending_results[$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int collisions_seen = 0;
   bit stimulus_done = 0;
   bit hold_rsp = 0;        // receiver back-pressure request from stimulus
   bit calm_phase = 0;      // stretch with no idling on either side

   // Floor square root of a value below 2^66, bit by bit from the top.
   function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] v);
      logic [ROOT_W-1:0]    r;
      logic [ROOT_W-1:0]    t;
      logic [2*ROOT_W-1:0]  t2;
      r = '0;
      for (int b = ROOT_W-1; b >= 0; b--) begin
         t = r | (34'd1 << b);
         t2 = t * t;
         if (t2 <= {2'b00, v}) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] clip32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Predict the collision result of one sphere/box pair.
   function automatic rsp_payload_type predict_contact(req_payload_type p);
      rsp_payload_type  r;
      logic signed [63:0] c[3], lo[3], hi[3], off[3], q, len, gap, sd;
      logic [SUM_W-1:0] sum;
      logic [63:0]      m;
      c[0] = 64'(p.sphere_x);  c[1] = 64'(p.sphere_y);  c[2] = 64'(p.sphere_z);
      lo[0] = 64'(p.box_min_x); lo[1] = 64'(p.box_min_y); lo[2] = 64'(p.box_min_z);
      hi[0] = 64'(p.box_max_x); hi[1] = 64'(p.box_max_y); hi[2] = 64'(p.box_max_z);
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         q = (c[i] < hi[i]) ? c[i] : hi[i];
         if (lo[i] > q) q = lo[i];
         off[i] = q - c[i];
         m = (off[i] < 0) ? -off[i] : off[i];
         sum = sum + SUM_W'(m) * SUM_W'(m);
      end
      len = 64'(floor_root(sum));
      gap = len - 64'(p.sphere_radius);
      sd = clip32(gap);
      r.collided = gap < 0;
      r.signed_distance = sd[31:0];
      // |off| < 2^32 and |sd| <= 2^31: the product fits in 64 bits.
      q = (len != 0) ? (off[0] * sd) / len : 0;  r.push_x = 32'(clip32(q));
      q = (len != 0) ? (off[1] * sd) / len : 0;  r.push_y = 32'(clip32(q));
      q = (len != 0) ? (off[2] * sd) / len : 0;  r.push_z = 32'(clip32(q));
      return r;
   endfunction

   // Directed rows; a typed-in expectation is used where has_expect is set.
   typedef struct {
      req_payload_type pair;
      bit              has_expect;
      rsp_payload_type expect_rsp;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic req_payload_type make_pair(
      int sx, int sy, int sz, int rad, int nx, int ny, int nz, int xx, int xy, int xz);
      req_payload_type p;
      p.sphere_x = sx; p.sphere_y = sy; p.sphere_z = sz;
      p.sphere_radius = rad[30:0];
      p.box_min_x = nx; p.box_min_y = ny; p.box_min_z = nz;
      p.box_max_x = xx; p.box_max_y = xy; p.box_max_z = xz;
      return p;
   endfunction

   task automatic add_row(req_payload_type p, bit known, rsp_payload_type e);
      directed_row_type row;
      row.pair = p; row.has_expect = known; row.expect_rsp = e;
      directed_rows.push_back(row);
   endtask

   task automatic build_table();
      localparam int MX = 32'h7fffffff;
      localparam int MN = 32'h80000000;
      localparam int ONE = 32'h00010000;
      rsp_payload_type e;
      // Centre inside the box: zero offset, distance is minus the radius.
      e = '{1'b1, -ONE, 0, 0, 0};
      add_row(make_pair(0, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1, e);
      // Zero radius, centre on the box surface: exactly touching, no collision.
      e = '{1'b0, 0, 0, 0, 0};
      add_row(make_pair(ONE, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1, e);
      // Largest radius inside the box.
      e = '{1'b1, -MX, 0, 0, 0};
      add_row(make_pair(0, 0, 0, MX, MN, MN, MN, MX, MX, MX), 1, e);
      // Offset of two units along +x, radius one: distance one, push (1,0,0).
      e = '{1'b0, ONE, ONE, 0, 0};
      add_row(make_pair(-2*ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE, ONE), 1, e);
      // Along -z, radius three: penetration of one unit, push points back.
      e = '{1'b1, -ONE, 0, 0, ONE};
      add_row(make_pair(0, 0, 3*ONE, 3*ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE), 1, e);
      // Extremes: corners at opposite ends of the range, saturating distance.
      e = '{1'b0, MX, 0, 0, 0};
      e.push_x = MX;
      add_row(make_pair(MN, 0, 0, 0, MX, MN, MN, MX, MX, MX), 0, e);
      add_row(make_pair(MN, MN, MN, 0, MX, MX, MX, MX, MX, MX), 0, e);
      add_row(make_pair(MX, MX, MX, 0, MN, MN, MN, MN, MN, MN), 0, e);
      add_row(make_pair(MX, MN, MX, MX, MN, MX, MN, MN, MX, MN), 0, e);
      add_row(make_pair(MN, MX, MN, MX, MX, MN, MX, MX, MN, MX), 0, e);
      // Inverted boxes: min above max on one or every axis.
      add_row(make_pair(0, 0, 0, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE), 0, e);
      add_row(make_pair(5, -7, 9, 3, MX, MX, MX, MN, MN, MN), 0, e);
      add_row(make_pair(ONE, ONE, ONE, 0, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0), 0, e);
      // Tiny offsets, one LSB away, and an all-axis diagonal.
      add_row(make_pair(-1, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE), 0, e);
      add_row(make_pair(-1, -1, -1, 1, 0, 0, 0, 0, 0, 0), 0, e);
      add_row(make_pair(-3*ONE, 4*ONE, 12*ONE, 5*ONE, 0, 0, 0, 0, 0, 0), 0, e);
      add_row(make_pair(-ONE, -ONE, -ONE, MX, 0, 0, 0, 0, 0, 0), 0, e);
      add_row(make_pair(MN, MN, MN, MX, MX, MX, MX, MX, MX, MX), 0, e);
      add_row(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0, e);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return int'($urandom);
         1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                        : 32'h80000000 + $urandom_range(0, 3);
         default: return int'($urandom_range(0, 32'h00400000)) - 32'sh00200000;
      endcase
   endfunction

   // Random pair: mostly local geometry so both hits and misses occur.
   function automatic req_payload_type random_pair();
      req_payload_type p;
      int a, b;
      p.sphere_x = rand_coord(); p.sphere_y = rand_coord(); p.sphere_z = rand_coord();
      case ($urandom_range(0, 3))
         0: p.sphere_radius = RADIUS_W'($urandom);
         1: p.sphere_radius = RADIUS_W'($urandom_range(0, 32'h00300000));
         default: p.sphere_radius = RADIUS_W'($urandom_range(0, 32'h00100000));
      endcase
      a = rand_coord(); b = rand_coord();
      // Most boxes well formed; about one in sixteen left inverted.
      if ($urandom_range(0, 7) != 0 && a > b) begin p.box_min_x = b; p.box_max_x = a; end
      else begin p.box_min_x = a; p.box_max_x = b; end
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 7) != 0 && a > b) begin p.box_min_y = b; p.box_max_y = a; end
      else begin p.box_min_y = a; p.box_max_y = b; end
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(0, 7) != 0 && a > b) begin p.box_min_z = b; p.box_max_z = a; end
      else begin p.box_min_z = a; p.box_max_z = b; end
      return p;
   endfunction

   // Offer one item; hold it steady until the handshake completes.
   task automatic send_pair(req_payload_type p, bit known, rsp_payload_type e);
      while (!calm_phase && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(known ? e : predict_contact(p));
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has been drained.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   initial begin : stimulus
      rsp_payload_type none;
      none = '0;
      build_table();
      repeat (2) @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].has_expect,
                   directed_rows[i].expect_rsp);
      // Sender pause: let the pipeline empty completely.
      drain_results();
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 200) hold_rsp = 1;          // receiver stalls, pipeline fills up
         if (n == 400) calm_phase = 1;        // idle-free stretch
         if (n == 600) calm_phase = 0;
         if (n == 800) drain_results();       // another full pause
         send_pair(random_pair(), 0, none);
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // Receiver: random idling, plus one long hold-off counted in cycles.
   initial begin : receiver
      int hold_count;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < 300; hold_count++) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_ready <= calm_phase || ($urandom_range(0, 99) >= 16);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_payload.collided) collisions_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected result %p", rsp_payload);
         end else begin
            e = pending_results.pop_front();
            if (rsp_payload.collided !== e.collided ||
                rsp_payload.signed_distance !== e.signed_distance ||
                rsp_payload.push_x !== e.push_x || rsp_payload.push_y !== e.push_y ||
                rsp_payload.push_z !== e.push_z) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch at result %0d: expected %p, got %p",
                           results_seen, e, rsp_payload);
            end
         end
      end
   end

   initial begin : finish_run
      wait (stimulus_done);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("%0d pairs sent, %0d results checked (%0d collisions), %0d mismatches",
               items_sent, results_seen, collisions_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timeout waiting for results");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sphere_box_collision_unit.f -----
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_sqrt.sv
hw/rtl/sbc_div.sv
hw/rtl/sphere_box_collision_unit.sv
hw/rtl/sbc_checker.sv
verif/sphere_box_collision_unit_test.sv
